[rtl/usr_pkg.sv]
// Shared constants and the distance conversion for the ultrasonic ranger.
package usr_pkg;

  localparam int TICK_W      = 20;
  localparam int DIST_W      = 15;
  localparam int STAT_W      = 2;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 20;
  localparam int IN_TDATA_W  = 8;
  localparam int OUT_TDATA_W = 56;
  // trig x3, dist x3, stat x3, plus round_done carried alongside
  localparam int RES_W       = 3 + 3 * DIST_W + 3 * STAT_W;
  localparam int BEAT_W      = RES_W + 1;

  localparam int DEFAULT_DIST_CM = 400;
  localparam logic [DIST_W-1:0] DIST_DEFAULT  = DIST_W'(DEFAULT_DIST_CM * 16);
  localparam logic [DIST_W-1:0] DIST_NO_START = DIST_W'(401 * 16);
  localparam logic [DIST_W-1:0] DIST_TOO_LONG = DIST_W'(402 * 16);

  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_NO_START = 2'd1;
  localparam logic [STAT_W-1:0] STAT_TOO_LONG = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_PRE_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TRIG_WIDTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_TO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ECHO_TO    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAP        = 3'd4;

  localparam logic [1:0] SEL_LEFT   = 2'd0;
  localparam logic [1:0] SEL_CENTER = 2'd1;
  localparam logic [1:0] SEL_RIGHT  = 2'd2;

  // ticks * 0.01715 cm in Q.4 == (ticks * 281) >> 10
  function automatic logic [DIST_W-1:0] ticks_to_q4(input logic [TICK_W-1:0] ticks);
    logic [TICK_W+8:0] prod;
    prod = {9'd0, ticks} * 29'd281;
    return prod[DIST_W+9:10];
  endfunction

endpackage

[rtl/ultrasonic_three_sensor_ranger_unit.sv]
// Top level of the three-sensor ultrasonic ranger: sequencer, result store, stream ports.
//
//  port group   dir  payload                                      beat meaning
//  s_axis       in   tdata[2:0] echo left/center/right            one microsecond tick
//  m_axis       out  tdata trig/dist/stat, tlast round_done       one result per tick
//  cfg          in   cfg_index, cfg_data                          one register write
//
// The sequencer state is updated from each accepted beat and the result is registered
// in the same cycle; the next tick can follow at once.
// A two-entry output register (result plus skid) keeps input taken while m_tready is low;
// s_tready drops only once both entries hold a result.
// rst (synchronous) restores the register defaults, puts the left sensor in pre-low
// and loads 400 cm, status ok into all stored and published results.
module ultrasonic_three_sensor_ranger_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [usr_pkg::IN_TDATA_W-1:0]      s_tdata,   // [0] left echo [1] center echo
                                                         // [2] right echo [7:3] zero
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [usr_pkg::OUT_TDATA_W-1:0]     m_tdata,   // [0] left trigger
                                                         // [1] center trigger
                                                         // [2] right trigger
                                                         // [17:3] dist_left
                                                         // [32:18] dist_center
                                                         // [47:33] dist_right
                                                         // [49:48] stat_left [51:50] stat_center
                                                         // [53:52] stat_right [55:54] zero
  output logic                                m_tlast,   // round_done
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [usr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [usr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import usr_pkg::*;

  typedef enum logic [2:0] {
    PH_PRE_LOW = 3'd0,
    PH_TRIG    = 3'd1,
    PH_WAIT    = 3'd2,
    PH_MEAS    = 3'd3,
    PH_GAP     = 3'd4
  } phase_t;

  logic [7:0]  pre_low_us;
  logic [7:0]  trigger_width_us;
  logic [15:0] start_timeout_us;
  logic [15:0] echo_max_us;
  logic [19:0] gap_us;

  phase_t              phase, phase_next;
  logic [1:0]          sensor_sel, sensor_sel_next;
  logic [TICK_W-1:0]   tick_count, tick_count_next;
  logic [DIST_W-1:0]   round_dist [3];
  logic [STAT_W-1:0]   round_stat [3];
  logic [DIST_W-1:0]   pub_dist [3];
  logic [STAT_W-1:0]   pub_stat [3];
  logic [DIST_W-1:0]   round_dist_next [3];
  logic [STAT_W-1:0]   round_stat_next [3];
  logic [DIST_W-1:0]   pub_dist_next [3];
  logic [STAT_W-1:0]   pub_stat_next [3];

  logic                accept;
  logic                done;
  logic [2:0]          trig;
  logic                echo;
  logic [7:0]          width;
  logic [TICK_W-1:0]   n;
  logic                rec;
  logic [DIST_W-1:0]   rec_dist;
  logic [STAT_W-1:0]   rec_stat;
  logic [BEAT_W-1:0]   res_beat;
  logic [BEAT_W-1:0]   out_beat;

  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    phase_next      = phase;
    sensor_sel_next = sensor_sel;
    tick_count_next = tick_count;
    round_dist_next = round_dist;
    round_stat_next = round_stat;
    pub_dist_next   = pub_dist;
    pub_stat_next   = pub_stat;
    done            = 1'b0;
    rec             = 1'b0;
    rec_dist        = DIST_DEFAULT;
    rec_stat        = STAT_OK;
    n               = tick_count + 20'd1;
    width           = (trigger_width_us == 8'd0) ? 8'd1 : trigger_width_us;

    // leave finished gap, pre-low and trigger phases at the start of the tick
    if (phase_next == PH_GAP && tick_count_next >= gap_us) begin
      if (sensor_sel_next == SEL_RIGHT) begin
        pub_dist_next   = round_dist;
        pub_stat_next   = round_stat;
        done            = 1'b1;
        sensor_sel_next = SEL_LEFT;
      end else begin
        sensor_sel_next = sensor_sel_next + 2'd1;
      end
      phase_next      = PH_PRE_LOW;
      tick_count_next = '0;
    end
    if (phase_next == PH_PRE_LOW && tick_count_next >= {12'd0, pre_low_us}) begin
      phase_next      = PH_TRIG;
      tick_count_next = '0;
    end
    if (phase_next == PH_TRIG && tick_count_next >= {12'd0, width}) begin
      phase_next      = PH_WAIT;
      tick_count_next = '0;
    end

    trig = 3'b000;
    if (phase_next == PH_TRIG) trig[sensor_sel_next] = 1'b1;

    unique case (sensor_sel_next)
      SEL_CENTER: echo = s_tdata[1];
      SEL_RIGHT:  echo = s_tdata[2];
      default:    echo = s_tdata[0];
    endcase

    unique case (phase_next)
      PH_PRE_LOW, PH_TRIG, PH_GAP: begin
        tick_count_next = tick_count_next + 20'd1;
      end
      PH_WAIT: begin
        if (echo) begin
          if (echo_max_us == 16'd0) begin
            rec      = 1'b1;
            rec_dist = DIST_TOO_LONG;
            rec_stat = STAT_TOO_LONG;
          end else begin
            phase_next      = PH_MEAS;
            tick_count_next = 20'd1;
          end
        end else begin
          tick_count_next = tick_count_next + 20'd1;
          if (tick_count_next > {4'd0, start_timeout_us}) begin
            rec      = 1'b1;
            rec_dist = DIST_NO_START;
            rec_stat = STAT_NO_START;
          end
        end
      end
      PH_MEAS: begin
        if (echo) begin
          if (n > {4'd0, echo_max_us}) begin
            rec      = 1'b1;
            rec_dist = DIST_TOO_LONG;
            rec_stat = STAT_TOO_LONG;
          end else begin
            tick_count_next = n;
          end
        end else begin
          rec      = 1'b1;
          rec_dist = ticks_to_q4(tick_count_next);
          rec_stat = STAT_OK;
        end
      end
      default: begin
        phase_next      = PH_PRE_LOW;
        tick_count_next = '0;
      end
    endcase

    if (rec) begin
      round_dist_next[sensor_sel_next] = rec_dist;
      round_stat_next[sensor_sel_next] = rec_stat;
      phase_next      = PH_GAP;
      tick_count_next = '0;
    end

    res_beat = {done, pub_stat_next[2], pub_stat_next[1], pub_stat_next[0],
                pub_dist_next[2], pub_dist_next[1], pub_dist_next[0], trig};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pre_low_us       <= 8'd2;
      trigger_width_us <= 8'd10;
      start_timeout_us <= 16'd15000;
      echo_max_us      <= 16'd30000;
      gap_us           <= 20'd20000;
      phase            <= PH_PRE_LOW;
      sensor_sel       <= SEL_LEFT;
      tick_count       <= '0;
      for (int i = 0; i < 3; i++) begin
        round_dist[i] <= DIST_DEFAULT;
        round_stat[i] <= STAT_OK;
        pub_dist[i]   <= DIST_DEFAULT;
        pub_stat[i]   <= STAT_OK;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_PRE_LOW:    pre_low_us       <= cfg_data[7:0];
          REG_TRIG_WIDTH: trigger_width_us <= cfg_data[7:0];
          REG_START_TO:   start_timeout_us <= cfg_data[15:0];
          REG_ECHO_TO:    echo_max_us      <= cfg_data[15:0];
          REG_GAP:        gap_us           <= cfg_data;
          default: ;  // drop writes beyond the register list
        endcase
      end
      if (accept) begin
        phase      <= phase_next;
        sensor_sel <= sensor_sel_next;
        tick_count <= tick_count_next;
        round_dist <= round_dist_next;
        round_stat <= round_stat_next;
        pub_dist   <= pub_dist_next;
        pub_stat   <= pub_stat_next;
      end
    end
  end

  usr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (res_beat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (out_beat)
  );

  assign m_tdata = {2'b00, out_beat[RES_W-1:0]};
  assign m_tlast = out_beat[RES_W];

  a_trig_onehot: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> $onehot0(m_tdata[2:0]))
    else $error("more than one trigger driven");

  a_stat_legal: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[49:48] != 2'd3 && m_tdata[51:50] != 2'd3 && m_tdata[53:52] != 2'd3)
    else $error("illegal status code");

  a_done_wraps: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> sensor_sel == SEL_LEFT && phase != PH_GAP)
    else $error("round end did not restart on the left sensor");

  a_sel_range: assert property (@(posedge clk) disable iff (rst)
    sensor_sel != 2'd3)
    else $error("sensor select out of range");

  a_echo_count_bound: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_WAIT || phase == PH_MEAS) |-> tick_count[TICK_W-1:17] == '0)
    else $error("echo tick count beyond timeout range");

endmodule

[rtl/usr_skid.sv]
// Output register with a skid stage for the ranger result stream.
module usr_skid (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [usr_pkg::BEAT_W-1:0] in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [usr_pkg::BEAT_W-1:0] out_data
);
  import usr_pkg::*;

  logic              skid_valid;
  logic [BEAT_W-1:0] skid_data;

  assign in_ready = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_data   <= skid_data;
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
        if (in_valid) out_data <= in_data;
      end
    end else if (in_valid && in_ready) begin
      // output stalled: park the beat
      skid_data  <= in_data;
      skid_valid <= 1'b1;
    end
  end

  a_skid_only_when_stalled: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid) && !$past(out_ready))
    else $error("skid filled while output was free");

endmodule
